// File: src/drre_pkg.sv
// Shared types and constants for the digit-run date range extractor.
`default_nettype none
package drre_pkg;

  localparam int unsigned ValueW  = 27;
  localparam int unsigned LenW    = 4;
  localparam int unsigned DateW   = 28;

  localparam logic [7:0]        CharZero    = 8'h30;
  localparam logic [7:0]        CharNine    = 8'h39;
  localparam logic [7:0]        CharEmpty   = 8'h00;
  localparam logic [LenW-1:0]   YearDigits  = 4'd4;
  localparam logic [LenW-1:0]   MaxDigits   = 4'd8;
  localparam logic [LenW-1:0]   LenSat      = 4'd9;
  localparam logic [ValueW-1:0] DateScale   = 27'd10000;
  localparam logic signed [DateW-1:0] NoDate = '1;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_string;
  } drre_in_t;

  typedef struct packed {
    logic signed [DateW-1:0] lowest_date;
    logic signed [DateW-1:0] highest_date;
  } drre_out_t;

  typedef struct packed {
    logic [ValueW-1:0] run_value;
    logic [LenW-1:0]   run_length;
    logic              found_any;
    logic [ValueW-1:0] min_seen;
    logic [ValueW-1:0] max_seen;
  } drre_state_t;

endpackage
`default_nettype wire

// File: src/drre_eval.sv
// Per-byte update: extends or closes a digit run and tracks the min/max date.
`default_nettype none
module drre_eval (
  input  drre_pkg::drre_state_t state_i,
  input  drre_pkg::drre_in_t    item_i,
  input  logic                  long_mode_i,
  output drre_pkg::drre_state_t state_o,
  output drre_pkg::drre_out_t   result_o
);
  import drre_pkg::*;

  logic              is_digit;
  logic [3:0]        digit;
  logic [ValueW-1:0] ext_value;
  logic [LenW-1:0]   ext_len;
  logic [ValueW-1:0] cand_value;
  logic [LenW-1:0]   cand_len;
  logic              close_en;
  logic              qualify;
  logic [ValueW-1:0] scaled;
  logic              take;
  logic              found_new;
  logic [ValueW-1:0] min_new;
  logic [ValueW-1:0] max_new;

  assign is_digit = (item_i.ch >= CharZero) && (item_i.ch <= CharNine);
  assign digit    = item_i.ch[3:0];

  // value*10 + digit as shift-add; the value stops growing past eight digits
  assign ext_value = (state_i.run_length < MaxDigits)
                   ? ({state_i.run_value[ValueW-4:0], 3'b000}
                      + {state_i.run_value[ValueW-2:0], 1'b0}
                      + {{(ValueW-4){1'b0}}, digit})
                   : state_i.run_value;
  assign ext_len   = (state_i.run_length < LenSat) ? state_i.run_length + 4'd1
                                                   : state_i.run_length;

  assign cand_value = is_digit ? ext_value : state_i.run_value;
  assign cand_len   = is_digit ? ext_len   : state_i.run_length;

  // a non-empty non-digit or the string end closes an open run
  assign close_en = (cand_len != '0)
                  && (item_i.end_of_string || (!is_digit && item_i.ch != CharEmpty));

  assign qualify = long_mode_i ? (cand_len >= YearDigits && cand_len <= MaxDigits)
                               : (cand_len == YearDigits);

  // a bare year in long-date mode becomes YYYY0000
  assign scaled = (long_mode_i && cand_len == YearDigits)
                ? ValueW'({13'd0, cand_value[13:0]} * DateScale)
                : cand_value;

  assign take      = close_en && qualify;
  assign found_new = state_i.found_any || take;
  assign min_new   = (take && (!state_i.found_any || scaled < state_i.min_seen))
                   ? scaled : state_i.min_seen;
  assign max_new   = (take && (!state_i.found_any || scaled > state_i.max_seen))
                   ? scaled : state_i.max_seen;

  always_comb begin
    state_o = state_i;
    if (item_i.end_of_string) begin
      state_o = '0;
    end else if (close_en) begin
      state_o.run_value  = '0;
      state_o.run_length = '0;
      state_o.found_any  = found_new;
      state_o.min_seen   = min_new;
      state_o.max_seen   = max_new;
    end else begin
      state_o.run_value  = cand_value;
      state_o.run_length = cand_len;
    end
  end

  always_comb begin
    if (found_new) begin
      result_o.lowest_date  = {1'b0, min_new};
      result_o.highest_date = {1'b0, max_new};
    end else begin
      result_o.lowest_date  = NoDate;
      result_o.highest_date = NoDate;
    end
  end

endmodule
`default_nettype wire

// File: src/digit_run_date_range_extractor_top.sv
// Top level of the digit-run date range extractor.
// Scans a string one byte per item and, on the item flagged end_of_string,
// returns the smallest and largest date found (-1 for both if none). In year
// mode a date is a run of exactly four digits; in long-date mode a run of four
// to eight digits, with a bare year scaled to YYYY0000. The block takes one
// item per clock unless an end-of-string item waits for a free output slot.
// The rate is set by the per-byte run and min/max update, which is combinational
// on the state registers. Write cfg_long_date_mode only while idle.
`default_nettype none
module digit_run_date_range_extractor_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  drre_pkg::drre_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output drre_pkg::drre_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_long_date_mode
);
  import drre_pkg::*;

  logic        in_vld_r;
  drre_in_t    in_item_r;
  logic        mode_r;
  drre_state_t state_r;
  drre_state_t state_nxt;
  drre_out_t   result_nxt;
  logic        out_vld_r;
  drre_out_t   out_data_r;
  logic        out_free;
  logic        advance;

  assign out_free = !out_vld_r || out_ready;
  // an item that emits a result waits for a free output slot
  assign advance  = in_vld_r && (!in_item_r.end_of_string || out_free);
  assign in_ready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  drre_eval u_eval (
    .state_i     (state_r),
    .item_i      (in_item_r),
    .long_mode_i (mode_r),
    .state_o     (state_nxt),
    .result_o    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      mode_r    <= 1'b0;
      state_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (cfg_valid) begin
        mode_r <= cfg_long_date_mode;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance && in_item_r.end_of_string) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
    if (advance && in_item_r.end_of_string) begin
      out_data_r <= result_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.run_length <= LenSat)
    else $error("run length beyond saturation");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.found_any |-> (state_r.min_seen <= state_r.max_seen))
    else $error("tracked minimum above maximum");

  a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_item_r.end_of_string) |=>
      (state_r.run_length == '0 && !state_r.found_any && out_vld_r))
    else $error("string end did not clear state or post a result");

  a_none_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.lowest_date == NoDate) |->
      (out_data_r.highest_date == NoDate))
    else $error("only one of the two dates is empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !(advance && in_item_r.end_of_string))
    else $error("result overwritten while waiting");
`endif

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench for the digit-run date range extractor: directed and random strings, each string's result checked.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import drre_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int unsigned RandomPhases = 6;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  drre_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  drre_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_long_date_mode = 1'b0;

  // predicted block state
  logic              mode_long = 1'b0;
  logic [ValueW-1:0] run_val = '0;
  logic [LenW-1:0]   run_len = '0;
  logic              date_seen = 1'b0;
  logic [ValueW-1:0] lo_date = '0;
  logic [ValueW-1:0] hi_date = '0;

  drre_out_t   dates_due[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned in_idle_odds = 0;
  int unsigned out_stall_odds = 0;
  int unsigned stall_left = 0;

  digit_run_date_range_extractor_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data            (in_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data           (out_data),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_long_date_mode (cfg_long_date_mode)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** digit_run_date_range_extractor_top: FAILED **");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
      stall_left <= $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    drre_out_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (dates_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item lowest %0d highest %0d",
                                  out_data.lowest_date, out_data.highest_date));
      end else begin
        want = dates_due.pop_front();
        if (out_data.lowest_date !== want.lowest_date)
          report_mismatch($sformatf("lowest_date expected %0d got %0d",
                                    want.lowest_date, out_data.lowest_date));
        if (out_data.highest_date !== want.highest_date)
          report_mismatch($sformatf("highest_date expected %0d got %0d",
                                    want.highest_date, out_data.highest_date));
      end
    end
  end

  // judge the open digit run and fold it into the range
  task automatic settle_run();
    logic              ok;
    logic [ValueW-1:0] v;
    v = run_val;
    ok = mode_long ? (run_len >= YearDigits && run_len <= MaxDigits) : (run_len == YearDigits);
    if (ok) begin
      if (mode_long && run_len == YearDigits) v = v * DateScale;
      if (!date_seen || v < lo_date) lo_date = v;
      if (!date_seen || v > hi_date) hi_date = v;
      date_seen = 1'b1;
    end
    run_val = '0;
    run_len = '0;
  endtask

  task automatic track_date_item(input drre_in_t it);
    drre_out_t res;
    if (it.ch >= CharZero && it.ch <= CharNine) begin
      if (run_len < MaxDigits) run_val = ValueW'(run_val * 10 + (it.ch - CharZero));
      if (run_len < LenSat) run_len = LenW'(run_len + 1);
    end else if (it.ch != CharEmpty && run_len != 0) begin
      settle_run();
    end
    if (it.end_of_string) begin
      if (run_len != 0) settle_run();
      if (date_seen) begin
        res.lowest_date = {1'b0, lo_date};
        res.highest_date = {1'b0, hi_date};
      end else begin
        res.lowest_date = NoDate;
        res.highest_date = NoDate;
      end
      dates_due.push_back(res);
      run_val = '0;
      run_len = '0;
      date_seen = 1'b0;
      lo_date = '0;
      hi_date = '0;
    end
  endtask

  task automatic send_item(input logic [7:0] c, input logic eos);
    drre_in_t it;
    it.ch = c;
    it.end_of_string = eos;
    if (in_idle_odds != 0 && $urandom_range(1, in_idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_date_item(it);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic close_string);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], close_string && i == s.len() - 1);
  endtask

  // drop valid and wait for every pending result plus the pipeline tail
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (dates_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    cfg_long_date_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_long = m;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_separator();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b >= CharZero && b <= CharNine);
    return b;
  endfunction

  task automatic test_year_mode();
    // reset default mode: years only
    send_item(CharEmpty, 1'b1);
    send_text("/0009", 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("9999", 1'b1);
    // an empty slot does not split a run
    send_text("12", 1'b0);
    send_item(CharEmpty, 1'b0);
    send_text("34", 1'b1);
    drain();
  endtask

  task automatic test_long_date_mode();
    write_mode(1'b1);
    // open run closed by an empty slot carrying end of string
    send_text("99999999:1900", 1'b0);
    send_item(CharEmpty, 1'b1);
    send_text("00000000", 1'b1);
    drain();
  endtask

  task automatic send_random_string();
    int unsigned tokens, k, n, d, kind;
    tokens = $urandom_range(0, 5);
    for (k = 0; k < tokens; k++) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: n = 4;
          4:          n = $urandom_range(1, 3);
          5, 6, 7:    n = $urandom_range(5, 8);
          8:          n = $urandom_range(9, 12);
          default:    n = 8;
        endcase
        for (d = 0; d < n; d++) send_item(CharZero + 8'($urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 4) != 0) send_item(pick_separator(), 1'b0);
      end else if (kind < 9) begin
        send_item(pick_separator(), 1'b0);
      end else begin
        send_item(CharEmpty, 1'b0);
      end
    end
    case ($urandom_range(0, 2))
      0:       send_item(CharZero + 8'($urandom_range(0, 9)), 1'b1);
      1:       send_item(pick_separator(), 1'b1);
      default: send_item(CharEmpty, 1'b1);
    endcase
  endtask

  task automatic test_random_strings();
    int unsigned phase, stop_at;
    for (phase = 0; phase < RandomPhases; phase++) begin
      write_mode(phase[0] ^ (phase >= 4 ? 1'b1 : 1'($urandom_range(0, 1))));
      if (phase == RandomPhases - 1 || phase == 2) begin
        in_idle_odds = 0;
        out_stall_odds = 0;
      end else begin
        in_idle_odds = $urandom_range(3, 8);
        out_stall_odds = $urandom_range(2, 6);
      end
      stop_at = items_sent + ItemsPerPhase;
      while (items_sent < stop_at) send_random_string();
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_year_mode();
    test_long_date_mode();
    in_idle_odds = 5;
    out_stall_odds = 4;
    test_random_strings();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && dates_due.size() == 0) begin
      $display("** digit_run_date_range_extractor_top: PASSED **");
    end else begin
      $display("** digit_run_date_range_extractor_top: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: digit_run_date_range_extractor_top.f
src/drre_pkg.sv
src/drre_eval.sv
src/digit_run_date_range_extractor_top.sv
sim/testbench.sv
